@@ rtl/core/rpmt_pkg.sv @@
// Package: route table commands, status codes and beat types.
`timescale 1ns / 1ps
`default_nettype none
package rpmt_pkg;

    localparam int ADDR_W   = 32;
    localparam int IFACE_W  = 4;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 3'd0,
        MODE_DELETE = 3'd1,
        MODE_LOOKUP = 3'd2,
        MODE_FLUSH  = 3'd3,
        MODE_SETDEF = 3'd4
    } mode_t;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [ADDR_W-1:0]  dest_addr;
        logic [ADDR_W-1:0]  gateway_addr;
        logic [ADDR_W-1:0]  net_mask;
        logic [IFACE_W-1:0] iface_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   next_hop;
        logic                via_gateway;
        logic [IFACE_W-1:0]  out_iface;
        logic [ADDR_W-1:0]   match_mask;
        logic [ADDR_W-1:0]   default_gw;
        logic [IFACE_W-1:0]  default_iface;
        logic                default_valid;
    } rsp_t;

    // Best-match / exact-match / free-slot info carried along the cell row.
    typedef struct packed {
        logic              exact_hit;
        logic              free_hit;
        logic              best_hit;
        logic [ADDR_W-1:0] win_mask;
        logic [ADDR_W-1:0] best_gw;
        logic              best_flag;
        logic [IFACE_W-1:0] best_iface;
    } scan_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic               wr_update;
        logic               wr_insert;
        logic               wr_delete;
        logic               flush;
        logic [ADDR_W-1:0]  dest;
        logic [ADDR_W-1:0]  mask;
        logic [ADDR_W-1:0]  gw;
        logic [IFACE_W-1:0] iface;
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

@@ rtl/core/rpmt_if.sv @@
// Interfaces: valid/ready request and response channels.
`timescale 1ns / 1ps
`default_nettype none
interface rpmt_req_if;
    import rpmt_pkg::*;
    logic valid;
    logic ready;
    logic [MODE_W-1:0]  mode;
    logic [ADDR_W-1:0]  dest_addr;
    logic [ADDR_W-1:0]  gateway_addr;
    logic [ADDR_W-1:0]  net_mask;
    logic [IFACE_W-1:0] iface_id;
    modport source (output valid, mode, dest_addr, gateway_addr, net_mask, iface_id,
                    input ready);
    modport sink (input valid, mode, dest_addr, gateway_addr, net_mask, iface_id,
                  output ready);
endinterface

interface rpmt_rsp_if;
    import rpmt_pkg::*;
    logic valid;
    logic ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   next_hop;
    logic                via_gateway;
    logic [IFACE_W-1:0]  out_iface;
    logic [ADDR_W-1:0]   match_mask;
    logic [ADDR_W-1:0]   default_gw;
    logic [IFACE_W-1:0]  default_iface;
    logic                default_valid;
    modport source (output valid, status, next_hop, via_gateway, out_iface, match_mask,
                    default_gw, default_iface, default_valid, input ready);
    modport sink (input valid, status, next_hop, via_gateway, out_iface, match_mask,
                  default_gw, default_iface, default_valid, output ready);
endinterface
`default_nettype wire

@@ rtl/core/route_prefix_match_table.sv @@
// Top level: IPv4 longest prefix match route table built as a row of cells.
//
// Usage:
//   req  (sink)  : one command beat {mode, dest_addr, gateway_addr, net_mask,
//                  iface_id}; taken when valid && ready.
//   rsp  (source): one result beat per command, held until rsp.ready.
// Each cell holds one route. A command is latched, then the scan front
// walks the row of TABLE_DEPTH cells, one cell per cycle, each cell
// folding its exact-match, free-slot and longest-mask result into the
// record it hands to its right neighbor. At the end of the row the
// sequencer decides the write (update, insert, delete or flush), which
// lands in the cells on the next edge, together with the result beat.
// One command in flight at a time: req.ready stays low from accept until
// the result beat is taken, so a new command waits for the last one to
// walk the whole cell row and return its result.
// Reset: every entry invalid, default gateway registers zero; no clearing
// pass. While rsp is stalled the result is held and req.ready stays low.
// Free slot on insert is the lowest invalid cell; lookup ties go to the
// lowest cell because a later cell wins only on a strictly larger mask.
`timescale 1ns / 1ps
`default_nettype none
module route_prefix_match_table
    import rpmt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int IFACE_BITS  = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    rpmt_req_if.sink  req,
    rpmt_rsp_if.source rsp
);
    scan_t scan_chain [TABLE_DEPTH+1];
    logic  exact_v [TABLE_DEPTH];
    logic  free_v  [TABLE_DEPTH];
    logic  is_exact [TABLE_DEPTH];
    logic  is_free  [TABLE_DEPTH];
    logic  any_exact;
    logic  in_fire;
    logic  scan_en;
    logic [ADDR_W-1:0] key;
    cmd_t  cmd;
    rsp_t  rsp_w;
    req_t  req_w;
    logic  in_ready;
    logic  out_valid;

    assign in_fire = req.valid && in_ready;
    assign req.ready = in_ready;

    always_comb
    begin
        req_w.mode         = req.mode;
        req_w.dest_addr    = req.dest_addr;
        req_w.gateway_addr = req.gateway_addr;
        req_w.net_mask     = req.net_mask;
        req_w.iface_id     = req.iface_id & IFACE_W'((1 << IFACE_BITS) - 1);
    end

    assign scan_chain[0] = '0;

    // Priority for write select: first exact / first free cell.
    always_comb
    begin
        logic seen_e;
        logic seen_f;
        seen_e = 1'b0;
        seen_f = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            is_exact[i] = exact_v[i] && !seen_e;
            is_free[i]  = free_v[i] && !seen_f;
            seen_e = seen_e | exact_v[i];
            seen_f = seen_f | free_v[i];
        end
        any_exact = seen_e;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        rpmt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .scan_en    (scan_en),
            .key        (key),
            .cmd        (cmd),
            .is_exact   (is_exact[g]),
            .is_free    (is_free[g]),
            .scan_in    (scan_chain[g]),
            .scan_out   (scan_chain[g+1]),
            .exact_here (exact_v[g]),
            .free_here  (free_v[g])
        );
    end

    rpmt_ctrl #(.SCAN_LEN(TABLE_DEPTH)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .req       (req_w),
        .out_ready (rsp.ready),
        .scan_tail (scan_chain[TABLE_DEPTH]),
        .any_exact (any_exact),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .scan_en   (scan_en),
        .key       (key),
        .cmd       (cmd),
        .rsp       (rsp_w)
    );

    assign rsp.valid         = out_valid;
    assign rsp.status        = rsp_w.status;
    assign rsp.next_hop      = rsp_w.next_hop;
    assign rsp.via_gateway   = rsp_w.via_gateway;
    assign rsp.out_iface     = rsp_w.out_iface;
    assign rsp.match_mask    = rsp_w.match_mask;
    assign rsp.default_gw    = rsp_w.default_gw;
    assign rsp.default_iface = rsp_w.default_iface;
    assign rsp.default_valid = rsp_w.default_valid;
endmodule
`default_nettype wire

@@ rtl/core/rpmt_cell.sv @@
// One route entry cell: stores an entry, compares and forwards scan results.
`timescale 1ns / 1ps
`default_nettype none
module rpmt_cell
    import rpmt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  scan_en,
    input  wire logic [ADDR_W-1:0] key,
    input  wire cmd_t  cmd,
    input  wire logic  is_exact,
    input  wire logic  is_free,
    input  wire scan_t scan_in,
    output scan_t      scan_out,
    output logic       exact_here,
    output logic       free_here
);
    logic               valid_reg;
    logic [ADDR_W-1:0]  dest_reg;
    logic [ADDR_W-1:0]  mask_reg;
    logic [ADDR_W-1:0]  gw_reg;
    logic               flag_reg;
    logic [IFACE_W-1:0] iface_reg;
    scan_t              scan_reg;
    scan_t              scan_next;
    logic               lpm;

    assign exact_here = valid_reg && dest_reg == cmd.dest && mask_reg == cmd.mask;
    assign free_here  = !valid_reg;
    assign lpm = valid_reg && ((key & mask_reg) == (dest_reg & mask_reg));

    always_comb
    begin
        scan_next = scan_in;
        scan_next.exact_hit = scan_in.exact_hit | exact_here;
        scan_next.free_hit  = scan_in.free_hit | free_here;
        if (lpm && (!scan_in.best_hit || mask_reg > scan_in.win_mask))
        begin
            scan_next.best_hit   = 1'b1;
            scan_next.win_mask   = mask_reg;
            scan_next.best_gw    = gw_reg;
            scan_next.best_flag  = flag_reg;
            scan_next.best_iface = iface_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.flush)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.wr_insert && is_free)
        begin
            valid_reg <= 1'b1;
        end
        else if (cmd.wr_delete && is_exact)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_en)
        begin
            scan_reg <= scan_next;
        end
        if (cmd.wr_insert && is_free)
        begin
            dest_reg  <= cmd.dest;
            mask_reg  <= cmd.mask;
            gw_reg    <= cmd.gw;
            flag_reg  <= cmd.gw != '0;
            iface_reg <= cmd.iface;
        end
        else if (cmd.wr_update && is_exact)
        begin
            gw_reg    <= cmd.gw;
            iface_reg <= cmd.iface;
            if (cmd.gw != '0)
            begin
                flag_reg <= 1'b1;
            end
        end
    end

    assign scan_out = scan_reg;
endmodule
`default_nettype wire

@@ rtl/core/rpmt_ctrl.sv @@
// Command sequencer: scan timing, table updates, default registers, result.
`timescale 1ns / 1ps
`default_nettype none
module rpmt_ctrl
    import rpmt_pkg::*;
#(
    parameter int SCAN_LEN = 64
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_fire,
    input  wire req_t  req,
    input  wire logic  out_ready,
    input  wire scan_t scan_tail,
    input  wire logic  any_exact,
    output logic       in_ready,
    output logic       out_valid,
    output logic       scan_en,
    output logic [ADDR_W-1:0] key,
    output cmd_t       cmd,
    output rsp_t       rsp
);
    localparam int CNT_W = $clog2(SCAN_LEN + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    req_t               req_reg;
    rsp_t               rsp_reg, rsp_next;
    logic [ADDR_W-1:0]  dgw_reg, dgw_next;
    logic [IFACE_W-1:0] dif_reg, dif_next;
    logic               dset_reg, dset_next;
    logic               is_add;
    logic [ADDR_W-1:0]  op_dest, op_mask;

    assign is_add  = req_reg.mode == MODE_ADD || req_reg.mode == MODE_SETDEF;
    assign op_dest = (req_reg.mode == MODE_SETDEF) ? '0 : req_reg.dest_addr;
    assign op_mask = (req_reg.mode == MODE_SETDEF) ? '0 : req_reg.net_mask;
    assign key     = req_reg.dest_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            dgw_reg   <= '0;
            dif_reg   <= '0;
            dset_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dgw_reg   <= dgw_next;
            dif_reg   <= dif_next;
            dset_reg  <= dset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rsp_next   = rsp_reg;
        dgw_next   = dgw_reg;
        dif_next   = dif_reg;
        dset_next  = dset_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        scan_en    = 1'b0;
        cmd        = '0;
        cmd.dest   = op_dest;
        cmd.mask   = op_mask;
        cmd.gw     = req_reg.gateway_addr;
        cmd.iface  = req_reg.iface_id;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                end
            end
            S_SCAN:
            begin
                scan_en = 1'b1;
                if (cnt_reg == CNT_W'(SCAN_LEN))
                begin
                    scan_en    = 1'b0;
                    state_next = S_OUT;
                    rsp_next   = '0;
                    rsp_next.status = ST_OK;
                    case (req_reg.mode)
                        MODE_ADD, MODE_SETDEF:
                        begin
                            if (scan_tail.exact_hit)
                            begin
                                cmd.wr_update = 1'b1;
                            end
                            else if (scan_tail.free_hit)
                            begin
                                cmd.wr_insert = 1'b1;
                            end
                            else
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            if ((scan_tail.exact_hit || scan_tail.free_hit)
                                && op_dest == '0 && op_mask == '0)
                            begin
                                dgw_next  = req_reg.gateway_addr;
                                dif_next  = req_reg.iface_id;
                                dset_next = 1'b1;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (scan_tail.exact_hit)
                            begin
                                cmd.wr_delete = 1'b1;
                                if (op_dest == '0 && op_mask == '0)
                                begin
                                    dgw_next  = '0;
                                    dif_next  = '0;
                                    dset_next = 1'b0;
                                end
                            end
                            else
                            begin
                                rsp_next.status = ST_NONE;
                            end
                        end
                        MODE_LOOKUP:
                        begin
                            if (scan_tail.best_hit)
                            begin
                                rsp_next.next_hop    = (scan_tail.best_gw == '0)
                                                       ? req_reg.dest_addr
                                                       : scan_tail.best_gw;
                                rsp_next.via_gateway = scan_tail.best_flag;
                                rsp_next.out_iface   = scan_tail.best_iface;
                                rsp_next.match_mask  = scan_tail.win_mask;
                            end
                            else
                            begin
                                rsp_next.status = ST_NONE;
                            end
                        end
                        MODE_FLUSH:
                        begin
                            cmd.flush = 1'b1;
                            dgw_next  = '0;
                            dif_next  = '0;
                            dset_next = 1'b0;
                        end
                        default:
                        begin
                            rsp_next.status = ST_NONE;
                        end
                    endcase
                    rsp_next.default_gw    = dgw_next;
                    rsp_next.default_iface = dif_next;
                    rsp_next.default_valid = dset_next;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp = rsp_reg;

    // The add path never both updates and inserts.
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_update && cmd.wr_insert))
        else $error("update and insert together");
    // Commands only at the end of a scan.
    a_cmd_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_update || cmd.wr_insert || cmd.wr_delete || cmd.flush)
        |-> state_reg == S_SCAN && cnt_reg == CNT_W'(SCAN_LEN))
        else $error("table write outside scan end");
    // An update is issued only when some cell in the row holds an exact match.
    a_exact: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_update |-> any_exact)
        else $error("update without matching cell");
    // Result holds while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rsp_reg))
        else $error("result changed under stall");
endmodule
`default_nettype wire
